### src/cti_pkg.sv
package cti_pkg;

  localparam int REG_W   = 16;
  localparam int NUM_W   = REG_W + 8;
  localparam int LEVEL_W = 8;
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = 1;
  localparam int QCNT_W  = 2;
  localparam int IDX_W   = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  localparam logic [IDX_W-1:0] REG_CROP_X       = 3'd0;
  localparam logic [IDX_W-1:0] REG_CROP_Y       = 3'd1;
  localparam logic [IDX_W-1:0] REG_CROP_WIDTH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROP_HEIGHT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIN_LOW      = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLATEAU_LOW  = 3'd5;
  localparam logic [IDX_W-1:0] REG_PLATEAU_HIGH = 3'd6;
  localparam logic [IDX_W-1:0] REG_WIN_HIGH     = 3'd7;

  typedef struct packed {
    logic [REG_W-1:0] crop_x;
    logic [REG_W-1:0] crop_y;
    logic [REG_W-1:0] crop_width;
    logic [REG_W-1:0] crop_height;
    logic [REG_W-1:0] win_low;
    logic [REG_W-1:0] plateau_low;
    logic [REG_W-1:0] plateau_high;
    logic [REG_W-1:0] win_high;
  } cfg_t;

  typedef struct packed {
    logic               is_ramp;
    logic [LEVEL_W-1:0] level;
    logic [NUM_W-1:0]   num;
    logic [REG_W-1:0]   div;
    logic               last;
  } entry_t;

endpackage

### src/cti_front.sv
module cti_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cti_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cti_pkg::REG_W-1:0] sample,
  input  logic                     row_end,
  input  logic                     slice_end,
  input  logic                     q_full,
  output logic                     q_push,
  output cti_pkg::entry_t          q_entry
);

  localparam int EW = cti_pkg::REG_W + 1;

  logic [COORD_BITS-1:0]     col_r, col_nxt;
  logic [COORD_BITS-1:0]     row_r, row_nxt;
  logic [EW-1:0]             col_e, row_e, x_end, y_end;
  logic [cti_pkg::REG_W-1:0] s;
  logic                      keep, acc;
  logic [cti_pkg::REG_W-1:0] diff;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  assign s     = cti_pkg::REG_W'(sample[SAMPLE_BITS-1:0]);
  assign col_e = {{(EW-COORD_BITS){1'b0}}, col_r};
  assign row_e = {{(EW-COORD_BITS){1'b0}}, row_r};
  assign x_end = {1'b0, cfg.crop_x} + {1'b0, cfg.crop_width};
  assign y_end = {1'b0, cfg.crop_y} + {1'b0, cfg.crop_height};

  assign keep = (col_e >= {1'b0, cfg.crop_x}) && (col_e < x_end) &&
                (row_e >= {1'b0, cfg.crop_y}) && (row_e < y_end);
  assign q_push = acc && keep;

  always_comb begin
    q_entry         = '0;
    q_entry.last    = ((col_e + EW'(1)) == x_end) && ((row_e + EW'(1)) == y_end);
    diff            = '0;
    priority if (s > cfg.win_high) begin
      q_entry.level = '0;
    end else if (s > cfg.plateau_high) begin
      q_entry.is_ramp = 1'b1;
      diff            = cfg.win_high - s;
      q_entry.div     = cfg.win_high - cfg.plateau_high;
    end else if (s >= cfg.plateau_low) begin
      q_entry.level = cti_pkg::FULL_LEVEL;
    end else if (s >= cfg.win_low) begin
      q_entry.is_ramp = 1'b1;
      diff            = s - cfg.win_low;
      q_entry.div     = cfg.plateau_low - cfg.win_low;
    end else begin
      q_entry.level = '0;
    end
    q_entry.num = {diff, 8'd0} - {8'd0, diff};
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      priority if (slice_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + COORD_BITS'(1);
      end else begin
        col_nxt = col_r + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### src/cti_queue.sv
module cti_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cti_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output cti_pkg::entry_t pop_entry
);

  cti_pkg::entry_t               mem_r [cti_pkg::QDEPTH];
  logic [cti_pkg::QIDX_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [cti_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == cti_pkg::QCNT_W'(cti_pkg::QDEPTH));
  assign empty     = (cnt_r == '0);
  assign pop_entry = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + cti_pkg::QCNT_W'(push) - cti_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/cti_back.sv
module cti_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  cti_pkg::entry_t             q_entry,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cti_pkg::LEVEL_W-1:0] out_tdata,
  output logic                        out_tlast
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cti_pkg::NUM_W-1:0]     rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [cti_pkg::LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic                          last_r, last_nxt;
  logic [2:0]                    cnt_r, cnt_nxt;
  logic                          ge;

  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_tvalid = (state_r == B_OUT);
  assign out_tdata  = lvl_r;
  assign out_tlast  = last_r;
  assign ge         = rem_r >= dsh_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    lvl_nxt   = lvl_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          last_nxt = q_entry.last;
          rem_nxt  = q_entry.num;
          dsh_nxt  = {1'b0, q_entry.div, 7'd0};
          cnt_nxt  = '0;
          lvl_nxt  = q_entry.level;
          state_nxt = q_entry.is_ramp ? B_DIV : B_OUT;
        end
      end
      B_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        dsh_nxt = {1'b0, dsh_r[cti_pkg::NUM_W-1:1]};
        lvl_nxt = {lvl_r[cti_pkg::LEVEL_W-2:0], ge};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_tready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    lvl_r  <= lvl_nxt;
    last_r <= last_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && cnt_r == 3'd7) |=> (state_r == B_OUT))
    else $error("divider did not finish after eight steps");
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("quotient exceeds eight bits");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (dsh_r != '0))
    else $error("ramp with zero divisor");
`endif

endmodule

### src/crop_trapezoid_intensity_map_core.sv
// Cropped-away samples are dropped in the front end; kept samples go through the queue
// to the back end, which handles one item at a time and pops the next only when idle.
// Ramp levels come from the shared 8-step restoring divider; plateau or zero levels skip it.
// A 2-entry queue between front and back lets input continue during a division.
// Reset (rst_n low, synchronous) clears the row and column counters, the queue
// and loads the register reset values.
module crop_trapezoid_intensity_map_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,  // sample
  input  logic [1:0]                        in_tuser,  // [1] slice_end, [0] row_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // level
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [cti_pkg::IDX_W-1:0]         cfg_addr,
  input  logic [cti_pkg::REG_W-1:0]         cfg_wdata
);

  cti_pkg::cfg_t   cfg_r;
  cti_pkg::entry_t push_entry, pop_entry;
  logic            q_full, q_empty, q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crop_x       <= '0;
      cfg_r.crop_y       <= '0;
      cfg_r.crop_width   <= 16'd1;
      cfg_r.crop_height  <= 16'd1;
      cfg_r.win_low      <= '0;
      cfg_r.plateau_low  <= '0;
      cfg_r.plateau_high <= 16'hFFFF;
      cfg_r.win_high     <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cti_pkg::REG_CROP_X:       cfg_r.crop_x       <= cfg_wdata;
        cti_pkg::REG_CROP_Y:       cfg_r.crop_y       <= cfg_wdata;
        cti_pkg::REG_CROP_WIDTH:   cfg_r.crop_width   <= cfg_wdata;
        cti_pkg::REG_CROP_HEIGHT:  cfg_r.crop_height  <= cfg_wdata;
        cti_pkg::REG_WIN_LOW:      cfg_r.win_low      <= cfg_wdata;
        cti_pkg::REG_PLATEAU_LOW:  cfg_r.plateau_low  <= cfg_wdata;
        cti_pkg::REG_PLATEAU_HIGH: cfg_r.plateau_high <= cfg_wdata;
        cti_pkg::REG_WIN_HIGH:     cfg_r.win_high     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cti_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sample    (in_tdata),
    .row_end   (in_tuser[0]),
    .slice_end (in_tuser[1]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  cti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .pop_entry  (pop_entry)
  );

  cti_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [15:0] sample;
    logic        row_end;
    logic        slice_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] level;
    logic       last;
  } mapped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [cti_pkg::IDX_W-1:0] cfg_addr = '0;
  logic [cti_pkg::REG_W-1:0] cfg_wdata = '0;

  crop_trapezoid_intensity_map_core dut (.*);

  always #4 clk = ~clk;

  pixel_t pixel_q[$];
  mapped_t mapped_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int accepted = 0;
  int queued = 0;
  longint cycles = 0;
  logic [15:0] regs[8];
  logic [15:0] col_cnt, row_cnt;

  function automatic logic [7:0] trapezoid(input logic [15:0] s);
    logic [31:0] r;
    if (s > regs[cti_pkg::REG_WIN_HIGH]) r = '0;
    else if (s > regs[cti_pkg::REG_PLATEAU_HIGH])
      r = (32'd255 * (regs[cti_pkg::REG_WIN_HIGH] - s)) /
          (regs[cti_pkg::REG_WIN_HIGH] - regs[cti_pkg::REG_PLATEAU_HIGH]);
    else if (s >= regs[cti_pkg::REG_PLATEAU_LOW]) r = 32'd255;
    else if (s >= regs[cti_pkg::REG_WIN_LOW])
      r = (32'd255 * (s - regs[cti_pkg::REG_WIN_LOW])) /
          (regs[cti_pkg::REG_PLATEAU_LOW] - regs[cti_pkg::REG_WIN_LOW]);
    else r = '0;
    return r[7:0];
  endfunction

  task automatic crop_and_map(input pixel_t p);
    logic [16:0] xe, ye;
    mapped_t m;
    xe = regs[cti_pkg::REG_CROP_X] + regs[cti_pkg::REG_CROP_WIDTH];
    ye = regs[cti_pkg::REG_CROP_Y] + regs[cti_pkg::REG_CROP_HEIGHT];
    if (col_cnt >= regs[cti_pkg::REG_CROP_X] && {1'b0, col_cnt} < xe &&
        row_cnt >= regs[cti_pkg::REG_CROP_Y] && {1'b0, row_cnt} < ye) begin
      m.level = trapezoid(p.sample);
      m.last = ({1'b0, col_cnt} + 17'd1 == xe) && ({1'b0, row_cnt} + 17'd1 == ye);
      mapped_q.push_back(m);
    end
    if (p.slice_end) begin
      col_cnt = '0;
      row_cnt = '0;
    end else if (p.row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 16'd1;
    end else begin
      col_cnt = col_cnt + 16'd1;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd100000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        crop_and_map({in_tdata, in_tuser[0], in_tuser[1]});
        accepted <= accepted + 1;
      end
      if ((in_tvalid && !in_tready) ||
          (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        if (!(in_tvalid && !in_tready)) begin
          pixel_t p;
          p = pixel_q.pop_front();
          in_tdata <= p.sample;
          in_tuser <= {p.slice_end, p.row_end};
          in_tvalid <= 1'b1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (mapped_q.size() == 0) begin
          $display("%0t: unexpected item level=%0d last=%0d", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          mapped_t m;
          m = mapped_q.pop_front();
          if (m.level !== out_tdata || m.last !== out_tlast) begin
            $display("%0t: mismatch expected level=%0d last=%0d actual level=%0d last=%0d",
                     $time, m.level, m.last, out_tdata, out_tlast);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_pixel(input logic [15:0] s, input logic re, input logic se);
    pixel_t p;
    p.sample = s;
    p.row_end = re;
    p.slice_end = se;
    pixel_q.push_back(p);
    queued++;
  endtask

  task automatic write_reg(input logic [cti_pkg::IDX_W-1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    regs[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int n;
    while (accepted < queued || in_tvalid || mapped_q.size() > 0) @(posedge clk);
    n = 0;
    while (n < 20) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic random_window();
    logic [15:0] a, b, c, d;
    a = 16'($urandom_range(65535));
    b = 16'($urandom_range(65535));
    c = 16'($urandom_range(65535));
    d = 16'($urandom_range(65535));
    if ($urandom_range(3) != 0) begin
      {a, b, c, d} = {a > b ? b : a, a > b ? a : b, c > d ? d : c, c > d ? c : d};
      if (b > c) {b, c} = {c, b};
      if (a > b) {a, b} = {b, a};
      if (c > d) {c, d} = {d, c};
    end
    write_reg(cti_pkg::REG_WIN_LOW, a);
    write_reg(cti_pkg::REG_PLATEAU_LOW, b);
    write_reg(cti_pkg::REG_PLATEAU_HIGH, c);
    write_reg(cti_pkg::REG_WIN_HIGH, d);
  endtask

  task automatic random_slice(input int w, input int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        add_pixel(16'($urandom_range(65535)), c == w - 1, (c == w - 1) && (r == h - 1));
  endtask

  initial begin
    regs[cti_pkg::REG_CROP_X] = '0;
    regs[cti_pkg::REG_CROP_Y] = '0;
    regs[cti_pkg::REG_CROP_WIDTH] = 16'd1;
    regs[cti_pkg::REG_CROP_HEIGHT] = 16'd1;
    regs[cti_pkg::REG_WIN_LOW] = '0;
    regs[cti_pkg::REG_PLATEAU_LOW] = '0;
    regs[cti_pkg::REG_PLATEAU_HIGH] = 16'hFFFF;
    regs[cti_pkg::REG_WIN_HIGH] = 16'hFFFF;
    col_cnt = '0;
    row_cnt = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_idle_pct = 27;
    recv_idle_pct = 81;
    write_reg(cti_pkg::REG_CROP_X, 16'd1);
    write_reg(cti_pkg::REG_CROP_Y, 16'd0);
    write_reg(cti_pkg::REG_CROP_WIDTH, 16'd3);
    write_reg(cti_pkg::REG_CROP_HEIGHT, 16'd2);
    write_reg(cti_pkg::REG_WIN_LOW, 16'd100);
    write_reg(cti_pkg::REG_PLATEAU_LOW, 16'd200);
    write_reg(cti_pkg::REG_PLATEAU_HIGH, 16'd300);
    write_reg(cti_pkg::REG_WIN_HIGH, 16'd400);
    add_pixel(16'd0, 1'b0, 1'b0);
    add_pixel(16'hFFFF, 1'b0, 1'b0);
    add_pixel(16'd99, 1'b0, 1'b0);
    add_pixel(16'd150, 1'b0, 1'b0);
    add_pixel(16'd250, 1'b1, 1'b0);
    add_pixel(16'd100, 1'b0, 1'b0);
    add_pixel(16'd350, 1'b0, 1'b0);
    add_pixel(16'd400, 1'b0, 1'b0);
    add_pixel(16'd401, 1'b0, 1'b0);
    add_pixel(16'hAAAA, 1'b1, 1'b1);
    add_pixel(16'h5555, 1'b1, 1'b1);
    drain();
    write_reg(cti_pkg::REG_CROP_WIDTH, 16'd0);
    add_pixel(16'd300, 1'b1, 1'b1);
    add_pixel(16'd300, 1'b0, 1'b0);
    drain();
    write_reg(cti_pkg::REG_CROP_X, 16'hFFFF);
    write_reg(cti_pkg::REG_CROP_Y, 16'hFFFF);
    write_reg(cti_pkg::REG_CROP_WIDTH, 16'hFFFF);
    write_reg(cti_pkg::REG_CROP_HEIGHT, 16'hFFFF);
    write_reg(cti_pkg::REG_WIN_LOW, 16'd500);
    write_reg(cti_pkg::REG_PLATEAU_LOW, 16'd100);
    write_reg(cti_pkg::REG_PLATEAU_HIGH, 16'd50);
    write_reg(cti_pkg::REG_WIN_HIGH, 16'd600);
    add_pixel(16'd550, 1'b1, 1'b1);
    add_pixel(16'h8000, 1'b0, 1'b1);
    drain();
    write_reg(cti_pkg::REG_CROP_X, 16'd0);
    write_reg(cti_pkg::REG_CROP_Y, 16'd0);
    add_pixel(16'd550, 1'b0, 1'b0);
    add_pixel(16'd40, 1'b0, 1'b0);
    add_pixel(16'd80, 1'b1, 1'b0);
    add_pixel(16'hFFFF, 1'b0, 1'b1);
    drain();

    // random slices
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 27 : ph == 1 ? 81 : 0;
      recv_idle_pct = ph == 0 ? 81 : ph == 1 ? 27 : 0;
      for (int k = 0; k < 12; k++) begin
        int w, h;
        w = $urandom_range(12, 1);
        h = $urandom_range(6, 1);
        write_reg(cti_pkg::REG_CROP_X, 16'($urandom_range(w)));
        write_reg(cti_pkg::REG_CROP_Y, 16'($urandom_range(h)));
        write_reg(cti_pkg::REG_CROP_WIDTH,
                  $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(w + 1)));
        write_reg(cti_pkg::REG_CROP_HEIGHT,
                  $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(h + 1)));
        random_window();
        random_slice(w, h);
        if ($urandom_range(3) == 0) begin
          for (int j = 0; j < 4; j++)
            add_pixel(16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        add_pixel(16'($urandom), 1'b1, 1'b1);
        drain();
      end
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
